// ===== src/ffc_pkg.sv =====
// Shared constants and types for the flat field corrector.
// No dependencies; compile first.
`default_nettype none

package ffc_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 8;
    localparam int CFG_W       = 17;

    // Largest frame the background store holds
    localparam int MAX_SAMPLES = 65536;

    // Operation codes of an input transfer
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CORRECT = 1'b1;

    // Derived widths
    localparam int IDX_W = $clog2(MAX_SAMPLES);            // store address
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);        // frame length
    localparam int SUM_W = IDX_W + SAMPLE_W;               // background sum
    localparam int REM_W = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;

    // One divider cell per quotient bit; quotients are sample wide
    localparam int QUO_W = SAMPLE_W;
    localparam int NCELL = QUO_W;

    localparam logic [SAMPLE_W-1:0] SAT_VAL = {SAMPLE_W{1'b1}};

    // Work item moving down the divider chain
    typedef struct packed {
        logic              valid;
        logic              is_mean;  // mean computation, no output
        logic              nomean;   // correction with no mean available
        logic              last;     // final sample of a corrected frame
        logic              sat;      // quotient known to exceed range
        logic              zero_b;   // background sample is zero
        logic              raw_nz;   // raw sample is nonzero
        logic [REM_W-1:0]  rem;      // partial remainder
        logic [REM_W-1:0]  div;      // divisor
        logic [QUO_W-1:0]  low;      // dividend bits not yet shifted in
        logic [QUO_W-1:0]  quo;      // quotient bits so far
    } t_div;

endpackage

`default_nettype wire

// ===== src/ffc_if.sv =====
// Valid/ready stream interfaces for the flat field corrector.
// Depends on ffc_pkg.
`default_nettype none

interface ffc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [ffc_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface ffc_out_if;
    logic                           valid;
    logic                           ready;
    logic [ffc_pkg::SAMPLE_W-1:0]   corrected;
    logic                           last_of_frame;
    logic                           fault;

    modport source (output valid, output corrected, output last_of_frame,
                    output fault, input ready);
    modport sink   (input valid, input corrected, input last_of_frame,
                    input fault, output ready);
endinterface

`default_nettype wire

// ===== src/ffc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ffc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ffc_cell.sv =====
// One restoring division step: shifts in one dividend bit, yields one
// quotient bit. Depends on ffc_pkg.
`default_nettype none

module ffc_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire ffc_pkg::t_div i_d,
    output ffc_pkg::t_div      o_q
);

    ffc_pkg::t_div                r_q;
    ffc_pkg::t_div                n_q;
    logic [ffc_pkg::REM_W:0]      w_trial;
    logic [ffc_pkg::REM_W:0]      w_diff;
    logic                         w_ge;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {i_d.rem, i_d.low[ffc_pkg::QUO_W-1]};
        w_diff  = w_trial - {1'b0, i_d.div};
        w_ge    = (w_trial >= {1'b0, i_d.div});
        n_q     = i_d;
        n_q.rem = w_ge ? w_diff[ffc_pkg::REM_W-1:0] : w_trial[ffc_pkg::REM_W-1:0];
        n_q.low = {i_d.low[ffc_pkg::QUO_W-2:0], 1'b0};
        n_q.quo = {i_d.quo[ffc_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== src/flat_field_corrector_core.sv =====
// Flat field corrector top level: background store, frame control, divider
// chain and output register. Depends on ffc_pkg, ffc_if, ffc_ram, ffc_cell.
//
// Background samples (operation 0) are taken one per cycle, while the output
// is not stalled and no mean division is busy, and written to the store while
// their sum builds up. Raw samples (operation 1) are also taken one per cycle
// under the same condition, and each gives one result: the store read and the
// issue register are loaded at the transfer edge, then the prep register holds
// the multiply, then each of the 8 cells of the division chain, and the output
// register. The final background sample of a frame sends the mean division
// down the same chain, and input is held off until the mean is known. A
// stalled output freezes the whole chain. The store has no reset; no clearing pass is run.
`default_nettype none

module flat_field_corrector_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ffc_pkg::CFG_W-1:0]   i_cfg_wdata,
    ffc_in_if.sink                           i_in,
    ffc_out_if.source                        o_out
);

    localparam int IDX_W = ffc_pkg::IDX_W;
    localparam int CNT_W = ffc_pkg::CNT_W;
    localparam int SUM_W = ffc_pkg::SUM_W;
    localparam int SW    = ffc_pkg::SAMPLE_W;

    // issue stage record
    typedef struct packed {
        logic              valid;
        logic              is_mean;
        logic              nomean;
        logic              last;
        logic [SW-1:0]     raw;
        logic [SW-1:0]     mean;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  len;
    } t_iss;

    function automatic logic [CNT_W-1:0] f_clamp(input logic [ffc_pkg::CFG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            f_clamp = CNT_W'(1);
        end else if (w > 32'(ffc_pkg::MAX_SAMPLES)) begin
            f_clamp = CNT_W'(ffc_pkg::MAX_SAMPLES);
        end else begin
            f_clamp = CNT_W'(w);
        end
    endfunction

    // control state
    logic [CNT_W-1:0]  r_len,      n_len;
    logic [IDX_W-1:0]  r_load_idx, n_load_idx;
    logic [IDX_W-1:0]  r_corr_idx, n_corr_idx;
    logic [SUM_W-1:0]  r_sum,      n_sum;
    logic [SW-1:0]     r_mean,     n_mean;
    logic              r_mready,   n_mready;
    logic              r_busy,     n_busy;

    t_iss              r_iss;
    ffc_pkg::t_div     r_prep, n_prep;
    ffc_pkg::t_div     w_stage [ffc_pkg::NCELL+1];
    ffc_pkg::t_div     w_tail;

    logic              r_out_valid;
    logic [SW-1:0]     r_out_corr;
    logic              r_out_last;
    logic              r_out_fault;

    logic              w_en;
    logic              w_acc;
    logic              w_load;
    logic              w_corr;
    logic              w_ld_last;
    logic              w_cr_last;
    logic              w_mean_done;
    logic [SUM_W-1:0]  w_sum_tot;
    logic [SW-1:0]     w_bg;
    logic [2*SW-1:0]   w_prod;

    // handshake and pipeline advance
    assign w_en        = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_en && !r_busy;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_load      = w_acc && (i_in.operation == ffc_pkg::OP_LOAD);
    assign w_corr      = w_acc && (i_in.operation == ffc_pkg::OP_CORRECT);
    assign w_ld_last   = (CNT_W'(r_load_idx) == (r_len - CNT_W'(1)));
    assign w_cr_last   = (CNT_W'(r_corr_idx) == (r_len - CNT_W'(1)));
    assign w_sum_tot   = ((r_load_idx == '0) ? '0 : r_sum) + SUM_W'(i_in.sample);
    assign w_tail      = w_stage[ffc_pkg::NCELL];
    assign w_mean_done = w_en && w_tail.valid && w_tail.is_mean;

    // frame control next state
    always_comb begin
        n_len      = r_len;
        n_load_idx = r_load_idx;
        n_corr_idx = r_corr_idx;
        n_sum      = r_sum;
        n_mean     = r_mean;
        n_mready   = r_mready;
        n_busy     = r_busy;
        if (w_load) begin
            if (r_load_idx == '0) begin
                n_mready   = 1'b0;
                n_corr_idx = '0;
            end
            if (w_ld_last) begin
                n_load_idx = '0;
                n_corr_idx = '0;
                n_sum      = '0;
                n_busy     = 1'b1;
            end else begin
                n_load_idx = r_load_idx + IDX_W'(1);
                n_sum      = w_sum_tot;
            end
        end
        if (w_corr && r_mready) begin
            n_corr_idx = w_cr_last ? '0 : (r_corr_idx + IDX_W'(1));
        end
        if (w_mean_done) begin
            n_mean   = w_tail.quo;
            n_mready = 1'b1;
            n_busy   = 1'b0;
        end
        if (i_cfg_we) begin
            n_len      = f_clamp(i_cfg_wdata);
            n_sum      = '0;
            n_load_idx = '0;
            n_corr_idx = '0;
            n_mready   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= CNT_W'(ffc_pkg::MAX_SAMPLES);
            r_load_idx <= '0;
            r_corr_idx <= '0;
            r_sum      <= '0;
            r_mean     <= '0;
            r_mready   <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_load_idx <= n_load_idx;
            r_corr_idx <= n_corr_idx;
            r_sum      <= n_sum;
            r_mean     <= n_mean;
            r_mready   <= n_mready;
            r_busy     <= n_busy;
        end
    end

    // background store: written on load, read on correction
    ffc_ram #(
        .WIDTH (SW),
        .DEPTH (ffc_pkg::MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_load_idx),
        .i_wdata (i_in.sample),
        .i_re    (w_corr),
        .i_raddr (r_corr_idx),
        .o_rdata (w_bg)
    );

    // issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= '0;
        end else if (w_en) begin
            r_iss.valid   <= w_corr || (w_load && w_ld_last);
            r_iss.is_mean <= w_load;
            r_iss.nomean  <= !r_mready;
            r_iss.last    <= r_mready && w_cr_last;
            r_iss.raw     <= i_in.sample;
            r_iss.mean    <= r_mean;
            r_iss.sum     <= w_sum_tot;
            r_iss.len     <= r_len;
        end
    end

    // prep stage: product, saturation check, divider operands
    assign w_prod = r_iss.raw * r_iss.mean;

    always_comb begin
        n_prep         = '0;
        n_prep.valid   = r_iss.valid;
        n_prep.is_mean = r_iss.is_mean;
        n_prep.nomean  = r_iss.nomean;
        n_prep.last    = r_iss.last;
        n_prep.raw_nz  = (r_iss.raw != '0);
        if (r_iss.is_mean) begin
            n_prep.rem = ffc_pkg::REM_W'(r_iss.sum[SUM_W-1:SW]);
            n_prep.low = r_iss.sum[SW-1:0];
            n_prep.div = ffc_pkg::REM_W'(r_iss.len);
        end else begin
            n_prep.rem    = ffc_pkg::REM_W'(w_prod[2*SW-1:SW]);
            n_prep.low    = w_prod[SW-1:0];
            n_prep.div    = ffc_pkg::REM_W'(w_bg);
            n_prep.sat    = (w_prod[2*SW-1:SW] >= w_bg);
            n_prep.zero_b = (w_bg == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= '0;
        end else if (w_en) begin
            r_prep <= n_prep;
        end
    end

    // division chain, one quotient bit per cell
    assign w_stage[0] = r_prep;

    for (genvar g = 0; g < ffc_pkg::NCELL; g++) begin : g_cell
        ffc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_stage[g]),
            .o_q     (w_stage[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tail.valid && !w_tail.is_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_last  <= w_tail.last;
            r_out_fault <= w_tail.nomean || w_tail.zero_b;
            if (w_tail.nomean) begin
                r_out_corr <= '0;
            end else if (w_tail.zero_b) begin
                r_out_corr <= w_tail.raw_nz ? ffc_pkg::SAT_VAL : '0;
            end else if (w_tail.sat) begin
                r_out_corr <= ffc_pkg::SAT_VAL;
            end else begin
                r_out_corr <= w_tail.quo;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.corrected     = r_out_corr;
    assign o_out.last_of_frame = r_out_last;
    assign o_out.fault         = r_out_fault;

    // checks
    a_load_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_load_idx) < r_len)
        else $error("load index past frame length");

    a_corr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_corr_idx) < r_len)
        else $error("correction index past frame length");

    a_mean_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prep.valid && r_prep.is_mean) |-> r_busy)
        else $error("mean division in chain without busy");

    a_mean_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mean_done |=> (r_mready && !r_busy))
        else $error("mean completion did not release input");

endmodule

`default_nettype wire

// ===== dv/flat_field_corrector_core_test.sv =====
// Self-checking testbench for flat_field_corrector_core: directed table, random frames, two fixed runs.
// Expected pixels come from a behavioral copy of the corrector kept in this module.
// Depends on ffc_pkg, ffc_if and the RTL of flat_field_corrector_core.
`default_nettype none

module flat_field_corrector_core_test;

    localparam int SAMPLE_W    = ffc_pkg::SAMPLE_W;
    localparam int CFG_W       = ffc_pkg::CFG_W;
    localparam int SUM_W       = ffc_pkg::SUM_W;
    localparam int MAX_SAMPLES = ffc_pkg::MAX_SAMPLES;

    localparam logic [SAMPLE_W-1:0] SAT_VAL = ffc_pkg::SAT_VAL;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int RANDOM_ITEMS   = 1340;
    localparam int DRAIN_CYCLES   = 16;     // mean division plus output register, with margin
    localparam int FLUSH_LIMIT    = 5000;
    localparam int MAX_REPORTS    = 40;

    localparam logic OP_LOAD    = ffc_pkg::OP_LOAD;
    localparam logic OP_CORRECT = ffc_pkg::OP_CORRECT;

    localparam logic [CFG_W-1:0] CNT_ALL_ONES = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] corrected;
        logic                last;
        logic                fault;
    } t_pixel_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // value is the count for a register row, the sample (low bits) otherwise
    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] value;
        logic             op;
        logic             typed;
        t_pixel_res       res;
    } t_dir_row;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ffc_in_if  in_if ();
    ffc_out_if out_if ();

    flat_field_corrector_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Behavioral state of the corrector
    logic [SAMPLE_W-1:0] bg_mem [MAX_SAMPLES];
    logic [SUM_W-1:0]    bg_sum;
    logic [SAMPLE_W-1:0] mean_lvl;
    logic                mean_valid;
    int unsigned         load_pos;
    int unsigned         corr_pos;
    logic [CFG_W-1:0]    count_reg;

    t_pixel_res pending_pixels [$];
    int         mismatch_cnt = 0;
    int         items_sent   = 0;
    bit         gaps_en      = 1'b1;
    int         stall_left   = 0;

    // Directed rows; typed expectations only where they follow directly
    t_dir_row dir_table [27] = '{
        // no mean after reset
        '{ROW_ITEM, 17'd255, OP_CORRECT, 1'b1, '{8'd0,   1'b0, 1'b1}},
        '{ROW_ITEM, 17'd0,   OP_CORRECT, 1'b1, '{8'd0,   1'b0, 1'b1}},
        // count 0 acts as a one-sample frame
        '{ROW_CFG,  17'd0,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd200, OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_CORRECT, 1'b1, '{8'd255, 1'b1, 1'b0}},
        '{ROW_ITEM, 17'd0,   OP_CORRECT, 1'b1, '{8'd0,   1'b1, 1'b0}},
        // zero background sample
        '{ROW_ITEM, 17'd0,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_CORRECT, 1'b1, '{8'd255, 1'b1, 1'b1}},
        '{ROW_ITEM, 17'd0,   OP_CORRECT, 1'b1, '{8'd0,   1'b1, 1'b1}},
        // four-sample frame, saturation and wrap to the next raw frame
        '{ROW_CFG,  17'd4,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd1,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_CORRECT, 1'b0, '0},
        '{ROW_ITEM, 17'd100, OP_CORRECT, 1'b0, '0},
        '{ROW_ITEM, 17'd0,   OP_CORRECT, 1'b0, '0},
        '{ROW_ITEM, 17'd7,   OP_CORRECT, 1'b0, '0},
        '{ROW_ITEM, 17'd128, OP_CORRECT, 1'b0, '0},
        // a new background frame drops the mean
        '{ROW_ITEM, 17'd9,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd5,   OP_CORRECT, 1'b1, '{8'd0,   1'b0, 1'b1}},
        // two-sample frame with a zero background entry
        '{ROW_CFG,  17'd2,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd3,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd0,   OP_LOAD,    1'b0, '0},
        '{ROW_ITEM, 17'd255, OP_CORRECT, 1'b0, '0},
        '{ROW_ITEM, 17'd0,   OP_CORRECT, 1'b1, '{8'd0,   1'b1, 1'b1}},
        '{ROW_ITEM, 17'd1,   OP_CORRECT, 1'b0, '0}
    };

    function automatic int unsigned frame_len();
        int unsigned n;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        return n;
    endfunction

    function automatic void clear_progress();
        bg_sum     = '0;
        load_pos   = 0;
        corr_pos   = 0;
        mean_valid = 1'b0;
    endfunction

    // Advance the corrector by one sample; returns 1 when a pixel comes out
    function automatic bit flat_field_step(input logic op, input logic [SAMPLE_W-1:0] s,
                                           output t_pixel_res res);
        int unsigned n;
        int unsigned b;
        int unsigned q;
        n   = frame_len();
        res = '0;
        if (op == OP_LOAD) begin
            if (load_pos >= n) load_pos = 0;
            if (load_pos == 0) begin
                mean_valid = 1'b0;
                corr_pos   = 0;
                bg_sum     = '0;
            end
            bg_mem[load_pos] = s;
            bg_sum           = bg_sum + s;
            load_pos++;
            if (load_pos >= n) begin
                mean_lvl   = SAMPLE_W'(bg_sum / n);
                mean_valid = 1'b1;
                load_pos   = 0;
                bg_sum     = '0;
                corr_pos   = 0;
            end
            return 1'b0;
        end
        if (!mean_valid) begin
            res.fault = 1'b1;
            return 1'b1;
        end
        if (corr_pos >= n) corr_pos = 0;
        b        = bg_mem[corr_pos];
        res.last = (corr_pos == n - 1);
        if (b == 0) begin
            res.corrected = (s != 0) ? SAT_VAL : '0;
            res.fault     = 1'b1;
        end else begin
            q = (int'(s) * int'(mean_lvl)) / b;
            res.corrected = (q > SAT_VAL) ? SAT_VAL : SAMPLE_W'(q);
        end
        corr_pos++;
        if (corr_pos >= n) corr_pos = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    // One input transfer; entered and left at a falling edge
    task automatic send_sample(input logic op, input logic [SAMPLE_W-1:0] s,
                               input bit typed, input t_pixel_res typed_res);
        t_pixel_res res;
        bit         makes;
        if (gaps_en && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.sample    <= s;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        makes = flat_field_step(op, s, res);
        if (makes) pending_pixels.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge clk);
    endtask

    // Count write once the block has gone quiet
    task automatic write_count(input logic [CFG_W-1:0] v);
        in_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        count_reg = v;
        clear_progress();
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SAT_VAL;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Background samples: uniform, flat around a level, or sprinkled with zeros
    task automatic load_background(input int unsigned cnt);
        int mode;
        int lvl;
        int v;
        mode = $urandom_range(0, 2);
        lvl  = $urandom_range(1, 255);
        for (int unsigned i = 0; i < cnt; i++) begin
            case (mode)
                0: v = $urandom_range(0, 255);
                1: begin
                    v = lvl + $urandom_range(0, 32) - 16;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                default: v = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
            endcase
            if ($urandom_range(0, 15) == 0) v = ($urandom_range(0, 1) == 0) ? 0 : 255;
            send_sample(OP_LOAD, SAMPLE_W'(v), 1'b0, '0);
        end
    endtask

    task automatic correct_raw(input int unsigned cnt);
        for (int unsigned i = 0; i < cnt; i++) send_sample(OP_CORRECT, pick_raw(), 1'b0, '0);
    endtask

    function automatic logic [CFG_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'($urandom_range(64, 160));
            default: return CFG_W'($urandom_range(2, 24));
        endcase
    endfunction

    // Output side: random stall bursts while gaps are enabled
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (gaps_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare each output transfer with the oldest pending pixel
    always @(posedge clk) begin
        t_pixel_res want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with nothing pending");
            end else begin
                want = pending_pixels.pop_front();
                if (out_if.corrected !== want.corrected)
                    report_mismatch($sformatf("corrected %0d, want %0d",
                                              out_if.corrected, want.corrected));
                if (out_if.last_of_frame !== want.last)
                    report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                              out_if.last_of_frame, want.last));
                if (out_if.fault !== want.fault)
                    report_mismatch($sformatf("fault %0b, want %0b",
                                              out_if.fault, want.fault));
            end
        end
    end

    initial begin
        int unsigned rand_goal;
        int unsigned n;
        int          waited;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_LOAD;
        in_if.sample    = '0;
        out_if.ready    = 1'b1;

        // predictor reset state
        count_reg = CFG_W'(MAX_SAMPLES);
        mean_lvl  = '0;
        clear_progress();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < $size(dir_table); i++) begin
            if (dir_table[i].kind == ROW_CFG)
                write_count(dir_table[i].value);
            else
                send_sample(dir_table[i].op, dir_table[i].value[SAMPLE_W-1:0],
                            dir_table[i].typed, dir_table[i].res);
        end

        // random frames: mostly load-then-correct, with stray and broken sequences
        rand_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < rand_goal) begin
            if ($urandom_range(0, 2) != 0) write_count(pick_count());
            n = frame_len();
            if ($urandom_range(0, 7) == 0) correct_raw($urandom_range(1, 4));
            if (n > 1 && $urandom_range(0, 7) == 0) begin
                load_background($urandom_range(1, n - 1));
                correct_raw($urandom_range(1, 3));
            end
            load_background(n);
            repeat ($urandom_range(1, 3)) correct_raw(n);
            if ($urandom_range(0, 3) == 0) correct_raw($urandom_range(1, n));
        end

        // count above range clamps to the store size; a partial frame leaves no mean
        write_count(CNT_ALL_ONES);
        load_background(8);
        correct_raw(4);

        // short frame, back to back to the end
        write_count(CFG_W'(16));
        gaps_en = 1'b0;
        load_background(16);
        correct_raw(40);

        in_if.valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < FLUSH_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never came out", pending_pixels.size()));
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/ffc_pkg.sv
src/ffc_if.sv
src/ffc_ram.sv
src/ffc_cell.sv
src/flat_field_corrector_core.sv
dv/flat_field_corrector_core_test.sv
